// File: rtl/edlp_pkg.sv
// ----------------------------------------------------------------------------
// edlp_pkg
// Shared types and constants for the debounce and long-press block.
// ----------------------------------------------------------------------------
package edlp_pkg;

    localparam int LEVEL_W = 17;
    localparam int COEF_W  = 16;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [COEF_W-1:0] FILTER_FACTOR_RST  = 16'd45875;
    localparam logic [COEF_W-1:0] TRIGGER_MARGIN_RST = 16'd6554;
    localparam logic [HOLD_W-1:0] LONG_PRESS_MS_RST  = 16'd1000;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FILTER_FACTOR  = 2'd0;
    localparam cfg_idx_t CFG_TRIGGER_MARGIN = 2'd1;
    localparam cfg_idx_t CFG_LONG_PRESS_MS  = 2'd2;

    typedef enum logic [1:0] {
        PRESS_OFF  = 2'd0,
        PRESS_ON   = 2'd1,
        PRESS_LONG = 2'd2
    } press_state_t;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic is_pressed;
        logic is_long_pressed;
        logic was_pressed;
        logic was_released;
        logic was_long_pressed;
        logic was_long_released;
    } result_t;

    typedef struct packed {
        cfg_idx_t          index;
        logic [COEF_W-1:0] data;
    } cfg_write_t;

endpackage

// File: rtl/edlp_if.sv
// ----------------------------------------------------------------------------
// edlp interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface edlp_sample_if;
    logic               valid;
    logic               ready;
    edlp_pkg::sample_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface edlp_result_if;
    logic               valid;
    logic               ready;
    edlp_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface edlp_cfg_if;
    logic                  valid;
    logic                  ready;
    edlp_pkg::cfg_write_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

// File: rtl/ema_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// ema_debounce_long_press_core
// Button debouncer with moving-average filter, hysteresis and long press.
// ----------------------------------------------------------------------------
// The block returns one result beat per sample beat. An accepted sample loads
// the input register; once the result register is free or being drained, its
// result loads the result register, which drives the port. The filter
// multiply, the trigger compares and the press state update sit between those
// two registers, so with the result side ready the block takes one sample per
// cycle. Register writes are always taken and should be made only while no
// sample is in flight.
// ----------------------------------------------------------------------------
module ema_debounce_long_press_core (
    input  logic         clk,
    input  logic         rst_n,
    edlp_sample_if.sink  samp,
    edlp_result_if.source evt,
    edlp_cfg_if.sink     cfg
);

    logic [edlp_pkg::COEF_W-1:0] factor_reg;
    logic [edlp_pkg::COEF_W-1:0] margin_reg;
    logic [edlp_pkg::HOLD_W-1:0] hold_reg;

    logic                         in_valid_reg;
    logic                         in_pin_reg;
    logic [edlp_pkg::TIME_W-1:0]  in_now_reg;

    logic [edlp_pkg::LEVEL_W-1:0] level_reg;
    logic [edlp_pkg::LEVEL_W-1:0] level_next;
    logic                         trig_reg;
    logic                         trig_next;
    edlp_pkg::press_state_t       state_reg;
    edlp_pkg::press_state_t       state_next;
    logic [edlp_pkg::TIME_W-1:0]  last_off_reg;
    logic [edlp_pkg::TIME_W-1:0]  last_off_next;

    logic                         out_valid_reg;
    edlp_pkg::result_t            out_reg;
    edlp_pkg::result_t            out_next;

    logic                         advance;
    logic [edlp_pkg::TIME_W-1:0]  elapsed;
    logic                         long_held;

    assign cfg.ready  = 1'b1;
    assign advance    = in_valid_reg && (!out_valid_reg || evt.ready);
    assign samp.ready = !in_valid_reg || advance;
    assign evt.valid  = out_valid_reg;
    assign evt.data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= edlp_pkg::FILTER_FACTOR_RST;
            margin_reg <= edlp_pkg::TRIGGER_MARGIN_RST;
            hold_reg   <= edlp_pkg::LONG_PRESS_MS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                edlp_pkg::CFG_FILTER_FACTOR:  factor_reg <= cfg.data.data;
                edlp_pkg::CFG_TRIGGER_MARGIN: margin_reg <= cfg.data.data;
                edlp_pkg::CFG_LONG_PRESS_MS:  hold_reg   <= cfg.data.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samp.ready)
        begin
            in_valid_reg <= samp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samp.valid && samp.ready)
        begin
            in_pin_reg <= samp.data.pin_level;
            in_now_reg <= samp.data.now_ms;
        end
    end

    edlp_filter u_filter (
        .level      (level_reg),
        .factor     (factor_reg),
        .margin     (margin_reg),
        .pin        (in_pin_reg),
        .trig       (trig_reg),
        .level_next (level_next),
        .trig_next  (trig_next)
    );

    // Wrapping subtraction keeps the hold time right across counter rollover.
    assign elapsed   = in_now_reg - last_off_reg;
    assign long_held = elapsed > {{(edlp_pkg::TIME_W-edlp_pkg::HOLD_W){1'b0}}, hold_reg};

    always_comb
    begin
        state_next    = state_reg;
        last_off_next = last_off_reg;
        out_next      = '0;
        if (trig_next)
        begin
            out_next.is_pressed = 1'b1;
            if (long_held)
            begin
                out_next.is_long_pressed = 1'b1;
                if (state_reg == edlp_pkg::PRESS_ON)
                begin
                    out_next.was_long_pressed = 1'b1;
                    state_next                = edlp_pkg::PRESS_LONG;
                end
            end
            else if (state_reg == edlp_pkg::PRESS_OFF)
            begin
                out_next.was_pressed = 1'b1;
                state_next           = edlp_pkg::PRESS_ON;
            end
        end
        else
        begin
            case (state_reg)
                edlp_pkg::PRESS_ON:   out_next.was_released      = 1'b1;
                edlp_pkg::PRESS_LONG: out_next.was_long_released = 1'b1;
                default: ;
            endcase
            state_next    = edlp_pkg::PRESS_OFF;
            last_off_next = in_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= edlp_pkg::ONE_Q16;
            trig_reg     <= 1'b0;
            state_reg    <= edlp_pkg::PRESS_OFF;
            last_off_reg <= '0;
        end
        else if (advance)
        begin
            level_reg    <= level_next;
            trig_reg     <= trig_next;
            state_reg    <= state_next;
            last_off_reg <= last_off_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/edlp_filter.sv
// ----------------------------------------------------------------------------
// edlp_filter
// Exponential moving average of the pin level in Q1.16 and the hysteresis
// trigger that follows it.
// ----------------------------------------------------------------------------
module edlp_filter (
    input  logic [edlp_pkg::LEVEL_W-1:0] level,
    input  logic [edlp_pkg::COEF_W-1:0]  factor,
    input  logic [edlp_pkg::COEF_W-1:0]  margin,
    input  logic                         pin,
    input  logic                         trig,
    output logic [edlp_pkg::LEVEL_W-1:0] level_next,
    output logic                         trig_next
);

    logic [edlp_pkg::LEVEL_W+edlp_pkg::COEF_W-1:0] prod;
    logic [edlp_pkg::LEVEL_W-1:0]                  comp;
    logic [edlp_pkg::LEVEL_W:0]                    sum;
    logic [edlp_pkg::LEVEL_W-1:0]                  hi_thr;

    // The new-sample term is a multiple of 2^16, so it adds after the shift
    // without changing the truncation.
    assign prod = level * factor;
    assign comp = pin ? (edlp_pkg::ONE_Q16 - {1'b0, factor}) : '0;
    assign sum  = {1'b0, prod[edlp_pkg::LEVEL_W+edlp_pkg::COEF_W-1:edlp_pkg::COEF_W]}
                + {1'b0, comp};
    assign level_next = sum[edlp_pkg::LEVEL_W-1:0];

    assign hi_thr = edlp_pkg::ONE_Q16 - {1'b0, margin};

    always_comb
    begin
        trig_next = trig;
        if (!trig && (level_next < {1'b0, margin}))
        begin
            trig_next = 1'b1;
        end
        else if (trig && (level_next > hi_thr))
        begin
            trig_next = 1'b0;
        end
    end

endmodule

// File: rtl/edlp_checker.sv
// ----------------------------------------------------------------------------
// edlp_checker
// Port-level checks on the result stream of the debounce block.
// ----------------------------------------------------------------------------
module edlp_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    input  logic              evt_ready,
    input  edlp_pkg::result_t evt_data
);

    // A result beat that is not taken must stay on the port.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_ready) |=> (evt_valid && $stable(evt_data)))
        else $error("result beat dropped or changed while stalled");

    // At most one transition flag per beat.
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> ($countones({evt_data.was_pressed, evt_data.was_released,
                                   evt_data.was_long_pressed,
                                   evt_data.was_long_released}) <= 1))
        else $error("more than one transition flag in a beat");

    // Long press is only ever reported while pressed.
    a_long_implies_press: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_data.is_long_pressed) |-> evt_data.is_pressed)
        else $error("long press flagged without press");

    // Transition flags agree with the level flags of the same beat.
    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |->
            (!evt_data.was_pressed || (evt_data.is_pressed && !evt_data.is_long_pressed))
         && (!evt_data.was_long_pressed || evt_data.is_long_pressed)
         && (!(evt_data.was_released || evt_data.was_long_released)
             || !evt_data.is_pressed))
        else $error("transition flag disagrees with level flags");

endmodule

bind ema_debounce_long_press_core edlp_checker u_edlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_data  (evt.data)
);
